// ----- hw/rtl/tbo_pkg.sv -----
// Shared types, widths and codes for the triangle/box overlap tester.
// Depends on nothing; every other file but tbo_fifo uses it by scoped names.
`timescale 1ns / 1ps

package tbo_pkg;

    // Coordinate format: signed fixed point, 8 fraction bits
    localparam int COORD_BITS = 24;
    localparam int CW  = COORD_BITS;
    localparam int EW  = CW + 1;          // edge and box-offset vectors
    localparam int PW  = 2 * EW;          // one edge-by-edge product
    localparam int SW  = PW + 2;          // sum of three such products
    localparam int NW  = PW + 1;          // triangle normal component
    localparam int KW  = EW;              // split point of the normal
    localparam int NHW = NW - KW;         // upper slice of the normal
    localparam int LW  = EW + KW + 1;     // offset times lower slice
    localparam int HW  = EW + NHW;        // offset times upper slice
    localparam int FPW = EW + NW;         // offset times full normal
    localparam int FSW = FPW + 2;         // sum of three of those

    localparam int NUM_EDGE_AXES = 9;
    localparam int QUEUE_DEPTH   = 4;
    localparam int OUT_DEPTH     = 16;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [EW-1:0] edge_t;
    typedef logic [3:0]           axis_t;

    // Axis codes in test order
    localparam axis_t AXIS_X         = 4'd0;
    localparam axis_t AXIS_Y         = 4'd1;
    localparam axis_t AXIS_Z         = 4'd2;
    localparam axis_t AXIS_NORMAL    = 4'd3;
    localparam axis_t AXIS_EDGE_BASE = 4'd4;
    localparam axis_t AXIS_NONE      = 4'd13;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5,
        REG_TOLERANCE = 3'd6
    } reg_idx_t;

    typedef struct packed {
        coord_t v0_x;
        coord_t v0_y;
        coord_t v0_z;
        coord_t v1_x;
        coord_t v1_y;
        coord_t v1_z;
        coord_t v2_x;
        coord_t v2_y;
        coord_t v2_z;
    } tri_in_t;

    typedef struct packed {
        logic  intersects;
        axis_t separating_axis;
    } result_t;

    typedef struct packed {
        coord_t          min_x;
        coord_t          min_y;
        coord_t          min_z;
        coord_t          max_x;
        coord_t          max_y;
        coord_t          max_z;
        logic [CW-2:0]   tol;
    } box_cfg_t;

    // Queue entry between classifier and projection pipeline
    typedef struct packed {
        tri_in_t tri_v;
        axis_t   box_axis;
    } work_t;

endpackage

// ----- hw/rtl/tbo_fifo.sv -----
// Small register-based FIFO used for the work queue and the result queue.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module tbo_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry on each push transfer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- hw/rtl/tbo_front.sv -----
// Front end: accepts triangles and runs the three box-axis tests.
// Depends on tbo_pkg; feeds the work queue.
`timescale 1ns / 1ps

module tbo_front (
    input  logic             push,
    output logic             full,
    input  tbo_pkg::tri_in_t item,
    input  tbo_pkg::box_cfg_t cfg,
    input  logic             q_full,
    output logic             q_push,
    output tbo_pkg::work_t   q_data
);

    tbo_pkg::coord_t v [3][3];
    tbo_pkg::coord_t bmin [3];
    tbo_pkg::coord_t bmax [3];
    logic signed [tbo_pkg::CW:0] tol_s;
    logic [2:0] sep;

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        v[0][0] = item.v0_x; v[0][1] = item.v0_y; v[0][2] = item.v0_z;
        v[1][0] = item.v1_x; v[1][1] = item.v1_y; v[1][2] = item.v1_z;
        v[2][0] = item.v2_x; v[2][1] = item.v2_y; v[2][2] = item.v2_z;
        bmin[0] = cfg.min_x; bmin[1] = cfg.min_y; bmin[2] = cfg.min_z;
        bmax[0] = cfg.max_x; bmax[1] = cfg.max_y; bmax[2] = cfg.max_z;
    end

    assign tol_s = $signed({2'b00, cfg.tol});

    // Widen the triangle extent on each axis and compare with the box
    always_comb
    begin
        tbo_pkg::coord_t lo, hi;
        logic signed [tbo_pkg::CW:0] lo_w, hi_w, bl, bh;
        for (int i = 0; i < 3; i++)
        begin
            lo = v[0][i];
            hi = v[0][i];
            for (int k = 1; k < 3; k++)
            begin
                if (v[k][i] < lo) lo = v[k][i];
                if (v[k][i] > hi) hi = v[k][i];
            end
            lo_w = (tbo_pkg::CW+1)'(lo) - tol_s;
            hi_w = (tbo_pkg::CW+1)'(hi) + tol_s;
            bl   = (tbo_pkg::CW+1)'(bmin[i]);
            bh   = (tbo_pkg::CW+1)'(bmax[i]);
            sep[i] = (lo_w < bl && hi_w < bl) || (lo_w > bh && hi_w > bh);
        end
    end

    // Pick the first separating box axis
    always_comb
    begin
        q_data.tri_v = item;
        if (sep[0])
        begin
            q_data.box_axis = tbo_pkg::AXIS_X;
        end
        else if (sep[1])
        begin
            q_data.box_axis = tbo_pkg::AXIS_Y;
        end
        else if (sep[2])
        begin
            q_data.box_axis = tbo_pkg::AXIS_Z;
        end
        else
        begin
            q_data.box_axis = tbo_pkg::AXIS_NONE;
        end
    end

endmodule

// ----- hw/rtl/tbo_back.sv -----
// Back end: projection pipeline for the normal axis and the NUM_EDGE_AXES edge-cross axes.
// Depends on tbo_pkg; reads the work queue, writes the result queue.
`timescale 1ns / 1ps

module tbo_back #(
    parameter int OUT_DEPTH = tbo_pkg::OUT_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  tbo_pkg::work_t    q_data,
    output logic              q_pop,
    input  tbo_pkg::box_cfg_t cfg,
    input  logic              res_taken,
    output logic              res_push,
    output tbo_pkg::result_t  res_data
);

    localparam int CNTW = $clog2(OUT_DEPTH + 1);
    localparam int NA   = tbo_pkg::NUM_EDGE_AXES;
    localparam int PW   = tbo_pkg::PW;
    localparam int SW   = tbo_pkg::SW;

    // Component i of edge k crossed with coordinate axis j
    function automatic tbo_pkg::edge_t axis_comp(input tbo_pkg::edge_t ex,
                                                 input tbo_pkg::edge_t ey,
                                                 input tbo_pkg::edge_t ez,
                                                 input int j, input int i);
        tbo_pkg::edge_t r;
        r = '0;
        case (j)
            0: begin
                if (i == 1) r = ez;
                if (i == 2) r = -ey;
            end
            1: begin
                if (i == 0) r = -ez;
                if (i == 2) r = ex;
            end
            2: begin
                if (i == 0) r = ey;
                if (i == 1) r = -ex;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    logic [CNTW-1:0] credit_reg, credit_next;
    logic [5:0]      vld_reg;

    // Stage 0: edges and box offsets relative to the first vertex
    tbo_pkg::edge_t e_next [3][3];
    tbo_pkg::edge_t dmin_next [3];
    tbo_pkg::edge_t dmax_next [3];
    tbo_pkg::edge_t s0_e_reg [3][3];
    tbo_pkg::edge_t s0_dmin_reg [3];
    tbo_pkg::edge_t s0_dmax_reg [3];
    tbo_pkg::axis_t s0_box_reg;

    // Stage 1: products
    logic signed [PW-1:0] s1_np_reg [6];
    logic signed [PW-1:0] s1_pmin_reg [NA][3];
    logic signed [PW-1:0] s1_pmax_reg [NA][3];
    logic signed [PW-1:0] s1_p1_reg [NA][3];
    logic signed [PW-1:0] s1_p2_reg [NA][3];
    tbo_pkg::edge_t       s1_dmin_reg [3];
    tbo_pkg::edge_t       s1_dmax_reg [3];
    tbo_pkg::axis_t       s1_box_reg;

    // Stage 2: normal and edge-axis sums
    logic signed [tbo_pkg::NW-1:0] s2_n_reg [3];
    logic signed [SW-1:0] s2_cmin_reg [NA];
    logic signed [SW-1:0] s2_cmax_reg [NA];
    logic signed [SW-1:0] s2_q1_reg [NA];
    logic signed [SW-1:0] s2_q2_reg [NA];
    tbo_pkg::edge_t       s2_dmin_reg [3];
    tbo_pkg::edge_t       s2_dmax_reg [3];
    tbo_pkg::axis_t       s2_box_reg;

    // Stage 3: edge-axis verdicts and split normal products
    logic [NA-1:0]                 s3_sep_reg;
    logic signed [tbo_pkg::LW-1:0] s3_lmin_reg [3];
    logic signed [tbo_pkg::LW-1:0] s3_lmax_reg [3];
    logic signed [tbo_pkg::HW-1:0] s3_hmin_reg [3];
    logic signed [tbo_pkg::HW-1:0] s3_hmax_reg [3];
    tbo_pkg::axis_t                s3_box_reg;

    // Stage 4: full normal products
    logic signed [tbo_pkg::FPW-1:0] s4_fmin_reg [3];
    logic signed [tbo_pkg::FPW-1:0] s4_fmax_reg [3];
    logic [NA-1:0]                  s4_sep_reg;
    tbo_pkg::axis_t                 s4_box_reg;

    // Stage 5: normal corner extremes
    logic signed [tbo_pkg::FSW-1:0] s5_cmin_reg;
    logic signed [tbo_pkg::FSW-1:0] s5_cmax_reg;
    logic [NA-1:0]                  s5_sep_reg;
    tbo_pkg::axis_t                 s5_box_reg;

    // Issue only when the result queue is sure to have room
    assign q_pop = !q_empty && (credit_reg < CNTW'(OUT_DEPTH));

    always_comb
    begin
        credit_next = credit_reg;
        if (q_pop && !res_taken)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!q_pop && res_taken)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            vld_reg    <= {vld_reg[4:0], q_pop};
        end
    end

    // Form edges and box offsets from the queue head
    always_comb
    begin
        tbo_pkg::coord_t v [3][3];
        tbo_pkg::coord_t bmin [3];
        tbo_pkg::coord_t bmax [3];
        v[0][0] = q_data.tri_v.v0_x; v[0][1] = q_data.tri_v.v0_y;
        v[0][2] = q_data.tri_v.v0_z;
        v[1][0] = q_data.tri_v.v1_x; v[1][1] = q_data.tri_v.v1_y;
        v[1][2] = q_data.tri_v.v1_z;
        v[2][0] = q_data.tri_v.v2_x; v[2][1] = q_data.tri_v.v2_y;
        v[2][2] = q_data.tri_v.v2_z;
        bmin[0] = cfg.min_x; bmin[1] = cfg.min_y; bmin[2] = cfg.min_z;
        bmax[0] = cfg.max_x; bmax[1] = cfg.max_y; bmax[2] = cfg.max_z;
        for (int i = 0; i < 3; i++)
        begin
            e_next[0][i] = tbo_pkg::EW'(v[1][i]) - tbo_pkg::EW'(v[0][i]);
            e_next[1][i] = tbo_pkg::EW'(v[2][i]) - tbo_pkg::EW'(v[1][i]);
            e_next[2][i] = tbo_pkg::EW'(v[2][i]) - tbo_pkg::EW'(v[0][i]);
            dmin_next[i] = tbo_pkg::EW'(bmin[i]) - tbo_pkg::EW'(v[0][i]);
            dmax_next[i] = tbo_pkg::EW'(bmax[i]) - tbo_pkg::EW'(v[0][i]);
        end
    end

    always_ff @(posedge clk)
    begin
        tbo_pkg::edge_t a;
        logic signed [SW-1:0] cmn, cmx, q1, q2, fmn, fmx;
        logic signed [tbo_pkg::NW-1:0] nn;
        logic signed [tbo_pkg::NHW-1:0] nh;
        logic signed [tbo_pkg::KW:0] nl;
        logic signed [tbo_pkg::FSW-1:0] smn, smx;

        // Stage 0: capture the edges
        s0_e_reg    <= e_next;
        s0_dmin_reg <= dmin_next;
        s0_dmax_reg <= dmax_next;
        s0_box_reg  <= q_data.box_axis;

        // Stage 1: normal products and edge-axis products
        s1_np_reg[0] <= s0_e_reg[0][1] * s0_e_reg[1][2];
        s1_np_reg[1] <= s0_e_reg[0][2] * s0_e_reg[1][1];
        s1_np_reg[2] <= s0_e_reg[0][2] * s0_e_reg[1][0];
        s1_np_reg[3] <= s0_e_reg[0][0] * s0_e_reg[1][2];
        s1_np_reg[4] <= s0_e_reg[0][0] * s0_e_reg[1][1];
        s1_np_reg[5] <= s0_e_reg[0][1] * s0_e_reg[1][0];
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    a = axis_comp(s0_e_reg[k][0], s0_e_reg[k][1], s0_e_reg[k][2], j, i);
                    s1_pmin_reg[k*3+j][i] <= a * s0_dmin_reg[i];
                    s1_pmax_reg[k*3+j][i] <= a * s0_dmax_reg[i];
                    s1_p1_reg[k*3+j][i]   <= a * s0_e_reg[0][i];
                    s1_p2_reg[k*3+j][i]   <= a * s0_e_reg[2][i];
                end
            end
        end
        s1_dmin_reg <= s0_dmin_reg;
        s1_dmax_reg <= s0_dmax_reg;
        s1_box_reg  <= s0_box_reg;

        // Stage 2: normal components and corner/vertex sums
        s2_n_reg[0] <= tbo_pkg::NW'(s1_np_reg[0]) - tbo_pkg::NW'(s1_np_reg[1]);
        s2_n_reg[1] <= tbo_pkg::NW'(s1_np_reg[2]) - tbo_pkg::NW'(s1_np_reg[3]);
        s2_n_reg[2] <= tbo_pkg::NW'(s1_np_reg[4]) - tbo_pkg::NW'(s1_np_reg[5]);
        for (int x = 0; x < NA; x++)
        begin
            cmn = '0;
            cmx = '0;
            q1  = '0;
            q2  = '0;
            for (int i = 0; i < 3; i++)
            begin
                if (s1_pmin_reg[x][i] < s1_pmax_reg[x][i])
                begin
                    cmn = cmn + SW'(s1_pmin_reg[x][i]);
                    cmx = cmx + SW'(s1_pmax_reg[x][i]);
                end
                else
                begin
                    cmn = cmn + SW'(s1_pmax_reg[x][i]);
                    cmx = cmx + SW'(s1_pmin_reg[x][i]);
                end
                q1 = q1 + SW'(s1_p1_reg[x][i]);
                q2 = q2 + SW'(s1_p2_reg[x][i]);
            end
            s2_cmin_reg[x] <= cmn;
            s2_cmax_reg[x] <= cmx;
            s2_q1_reg[x]   <= q1;
            s2_q2_reg[x]   <= q2;
        end
        s2_dmin_reg <= s1_dmin_reg;
        s2_dmax_reg <= s1_dmax_reg;
        s2_box_reg  <= s1_box_reg;

        // Stage 3: edge-axis verdicts; normal times offsets in two slices
        for (int x = 0; x < NA; x++)
        begin
            fmn = '0;
            fmx = '0;
            if (s2_q1_reg[x] < fmn) fmn = s2_q1_reg[x];
            if (s2_q2_reg[x] < fmn) fmn = s2_q2_reg[x];
            if (s2_q1_reg[x] > fmx) fmx = s2_q1_reg[x];
            if (s2_q2_reg[x] > fmx) fmx = s2_q2_reg[x];
            s3_sep_reg[x] <= (fmx < s2_cmin_reg[x]) || (s2_cmax_reg[x] < fmn);
        end
        for (int i = 0; i < 3; i++)
        begin
            nn = s2_n_reg[i];
            nh = $signed(nn[tbo_pkg::NW-1:tbo_pkg::KW]);
            nl = $signed({1'b0, nn[tbo_pkg::KW-1:0]});
            s3_lmin_reg[i] <= s2_dmin_reg[i] * nl;
            s3_lmax_reg[i] <= s2_dmax_reg[i] * nl;
            s3_hmin_reg[i] <= s2_dmin_reg[i] * nh;
            s3_hmax_reg[i] <= s2_dmax_reg[i] * nh;
        end
        s3_box_reg <= s2_box_reg;

        // Stage 4: join the slices
        for (int i = 0; i < 3; i++)
        begin
            s4_fmin_reg[i] <= (tbo_pkg::FPW'(s3_hmin_reg[i]) <<< tbo_pkg::KW)
                              + tbo_pkg::FPW'(s3_lmin_reg[i]);
            s4_fmax_reg[i] <= (tbo_pkg::FPW'(s3_hmax_reg[i]) <<< tbo_pkg::KW)
                              + tbo_pkg::FPW'(s3_lmax_reg[i]);
        end
        s4_sep_reg <= s3_sep_reg;
        s4_box_reg <= s3_box_reg;

        // Stage 5: nearest and farthest box corner along the normal
        smn = '0;
        smx = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (s4_fmin_reg[i] < s4_fmax_reg[i])
            begin
                smn = smn + tbo_pkg::FSW'(s4_fmin_reg[i]);
                smx = smx + tbo_pkg::FSW'(s4_fmax_reg[i]);
            end
            else
            begin
                smn = smn + tbo_pkg::FSW'(s4_fmax_reg[i]);
                smx = smx + tbo_pkg::FSW'(s4_fmin_reg[i]);
            end
        end
        s5_cmin_reg <= smn;
        s5_cmax_reg <= smx;
        s5_sep_reg  <= s4_sep_reg;
        s5_box_reg  <= s4_box_reg;
    end

    // Resolve the first separating axis in test order
    always_comb
    begin
        tbo_pkg::axis_t ax;
        ax = tbo_pkg::AXIS_NONE;
        if (s5_box_reg != tbo_pkg::AXIS_NONE)
        begin
            ax = s5_box_reg;
        end
        else if (s5_cmin_reg > 0 || s5_cmax_reg < 0)
        begin
            ax = tbo_pkg::AXIS_NORMAL;
        end
        else
        begin
            for (int x = NA - 1; x >= 0; x--)
            begin
                if (s5_sep_reg[x])
                begin
                    ax = tbo_pkg::AXIS_EDGE_BASE + 4'(x);
                end
            end
        end
        res_data.separating_axis = ax;
        res_data.intersects      = (ax == tbo_pkg::AXIS_NONE);
    end

    assign res_push = vld_reg[5];

endmodule

// ----- hw/rtl/triangle_box_overlap_test_top.sv -----
// Triangle versus box overlap tester, 13-axis separating-axis test.
// Path from input transfer to result: work queue, 6 stages, result queue.
// Throughput: one triangle per cycle while full is low, set by the fully pipelined stages.
// Reset: clears box and tolerance registers to 0 and empties both queues.
// Depends on tbo_pkg, tbo_fifo, tbo_front and tbo_back.
`timescale 1ns / 1ps

module triangle_box_overlap_test_top #(
    parameter int QUEUE_DEPTH = tbo_pkg::QUEUE_DEPTH,
    parameter int OUT_DEPTH   = tbo_pkg::OUT_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  tbo_pkg::tri_in_t           item,
    output logic                       empty,
    input  logic                       pop,
    output tbo_pkg::result_t           result,
    input  logic                       wr_en,
    input  logic [2:0]                 wr_index,
    input  logic [tbo_pkg::CW-1:0]     wr_data
);

    tbo_pkg::box_cfg_t cfg_reg;
    tbo_pkg::work_t    fq_wdata, fq_rdata;
    tbo_pkg::result_t  res_data;
    logic              fq_push, fq_full, fq_pop, fq_empty;
    logic              res_push, res_full;

    // Hold configuration written through the register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                tbo_pkg::REG_BOX_MIN_X: cfg_reg.min_x <= wr_data;
                tbo_pkg::REG_BOX_MIN_Y: cfg_reg.min_y <= wr_data;
                tbo_pkg::REG_BOX_MIN_Z: cfg_reg.min_z <= wr_data;
                tbo_pkg::REG_BOX_MAX_X: cfg_reg.max_x <= wr_data;
                tbo_pkg::REG_BOX_MAX_Y: cfg_reg.max_y <= wr_data;
                tbo_pkg::REG_BOX_MAX_Z: cfg_reg.max_z <= wr_data;
                tbo_pkg::REG_TOLERANCE: cfg_reg.tol   <= wr_data[tbo_pkg::CW-2:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    tbo_front u_front (
        .push   (push),
        .full   (full),
        .item   (item),
        .cfg    (cfg_reg),
        .q_full (fq_full),
        .q_push (fq_push),
        .q_data (fq_wdata)
    );

    tbo_fifo #(
        .WIDTH ($bits(tbo_pkg::work_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_wdata),
        .full  (fq_full),
        .pop   (fq_pop),
        .rdata (fq_rdata),
        .empty (fq_empty)
    );

    tbo_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (fq_empty),
        .q_data    (fq_rdata),
        .q_pop     (fq_pop),
        .cfg       (cfg_reg),
        .res_taken (pop && !empty),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Result queue; the back end's credit count keeps it from overflowing
    tbo_fifo #(
        .WIDTH ($bits(tbo_pkg::result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    logic unused_full;
    assign unused_full = res_full;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the triangle/box overlap tester.
// Depends on tbo_pkg and triangle_box_overlap_test_top; predicts each verdict exactly.
`timescale 1ns / 1ps

module tb_top;

    typedef logic signed [127:0] w_t;

    localparam logic [2:0] REG_UNUSED  = 3'd7;
    localparam int         WATCH_LIMIT = 20000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         SETTLE      = 12;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    tbo_pkg::tri_in_t          item;
    logic                      empty;
    logic                      pop;
    tbo_pkg::result_t          result;
    logic                      wr_en;
    logic [2:0]                wr_index;
    logic [tbo_pkg::CW-1:0]    wr_data;

    // predictor copy of the box registers
    w_t              box_lo [3];
    w_t              box_hi [3];
    w_t              tol_val;

    tbo_pkg::result_t verdict_q [$];
    int              mismatches;
    int              stall_cnt;
    bit              quiet;
    int              hold_req;
    int              hold_seen;
    int              hold_left;

    triangle_box_overlap_test_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Project the box corners and the vertices on one axis and compare extents
    function automatic bit axis_separates(input w_t a0, input w_t a1, input w_t a2,
                                          input w_t v[3][3]);
        w_t px;
        w_t py;
        w_t pz;
        w_t d;
        w_t cmin;
        w_t cmax;
        w_t fmin;
        w_t fmax;
        cmin = 0;
        cmax = 0;
        fmin = 0;
        fmax = 0;
        for (int c = 0; c < 8; c++)
        begin
            px = c[0] ? box_hi[0] : box_lo[0];
            py = c[1] ? box_hi[1] : box_lo[1];
            pz = c[2] ? box_hi[2] : box_lo[2];
            d = px * a0 + py * a1 + pz * a2;
            if (c == 0 || d < cmin) cmin = d;
            if (c == 0 || d > cmax) cmax = d;
        end
        for (int k = 0; k < 3; k++)
        begin
            d = v[k][0] * a0 + v[k][1] * a1 + v[k][2] * a2;
            if (k == 0 || d < fmin) fmin = d;
            if (k == 0 || d > fmax) fmax = d;
        end
        return (fmax < cmin) || (cmax < fmin);
    endfunction

    // Expected verdict for one triangle against the current box
    function automatic tbo_pkg::result_t classify_tri(input tbo_pkg::tri_in_t t);
        w_t               v [3][3];
        w_t               e [3][3];
        w_t               lo;
        w_t               hi;
        w_t               a0;
        w_t               a1;
        w_t               a2;
        tbo_pkg::axis_t   axis;
        tbo_pkg::result_t r;
        v[0][0] = t.v0_x; v[0][1] = t.v0_y; v[0][2] = t.v0_z;
        v[1][0] = t.v1_x; v[1][1] = t.v1_y; v[1][2] = t.v1_z;
        v[2][0] = t.v2_x; v[2][1] = t.v2_y; v[2][2] = t.v2_z;
        axis = tbo_pkg::AXIS_NONE;
        for (int i = 0; i < 3; i++)
        begin
            lo = v[0][i];
            hi = v[0][i];
            for (int k = 1; k < 3; k++)
            begin
                if (v[k][i] < lo) lo = v[k][i];
                if (v[k][i] > hi) hi = v[k][i];
            end
            lo = lo - tol_val;
            hi = hi + tol_val;
            if (axis == tbo_pkg::AXIS_NONE &&
                ((lo < box_lo[i] && hi < box_lo[i]) || (lo > box_hi[i] && hi > box_hi[i])))
                axis = tbo_pkg::axis_t'(i);
        end
        for (int i = 0; i < 3; i++)
        begin
            e[0][i] = v[1][i] - v[0][i];
            e[1][i] = v[2][i] - v[1][i];
            e[2][i] = v[2][i] - v[0][i];
        end
        a0 = e[0][1] * e[1][2] - e[0][2] * e[1][1];
        a1 = e[0][2] * e[1][0] - e[0][0] * e[1][2];
        a2 = e[0][0] * e[1][1] - e[0][1] * e[1][0];
        if (axis == tbo_pkg::AXIS_NONE && axis_separates(a0, a1, a2, v))
            axis = tbo_pkg::AXIS_NORMAL;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (j == 0)
                begin
                    a0 = 0; a1 = e[k][2]; a2 = -e[k][1];
                end
                else if (j == 1)
                begin
                    a0 = -e[k][2]; a1 = 0; a2 = e[k][0];
                end
                else
                begin
                    a0 = e[k][1]; a1 = -e[k][0]; a2 = 0;
                end
                if (axis == tbo_pkg::AXIS_NONE && axis_separates(a0, a1, a2, v))
                    axis = tbo_pkg::AXIS_EDGE_BASE + tbo_pkg::axis_t'(k * 3 + j);
            end
        end
        r.intersects      = (axis == tbo_pkg::AXIS_NONE);
        r.separating_axis = axis;
        return r;
    endfunction

    // Offer one triangle; push stays high on return so back-to-back transfers can follow
    task automatic send_tri(input tbo_pkg::tri_in_t t);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 17)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
        verdict_q = {verdict_q, classify_tri(t)};
    endtask

    // Drop push and wait until every verdict has come back and the pipe is empty
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [tbo_pkg::CW-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        if (idx < tbo_pkg::REG_BOX_MAX_X)
            box_lo[idx] = w_t'($signed(data));
        else if (idx < tbo_pkg::REG_TOLERANCE)
            box_hi[idx - 3] = w_t'($signed(data));
        else if (idx == tbo_pkg::REG_TOLERANCE)
            tol_val = w_t'({1'b0, data[tbo_pkg::CW-2:0]});
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic set_box(input int lx, input int ly, input int lz,
                           input int hx, input int hy, input int hz, input int tol);
        drain();
        write_reg(tbo_pkg::REG_BOX_MIN_X, lx[tbo_pkg::CW-1:0]);
        write_reg(tbo_pkg::REG_BOX_MIN_Y, ly[tbo_pkg::CW-1:0]);
        write_reg(tbo_pkg::REG_BOX_MIN_Z, lz[tbo_pkg::CW-1:0]);
        write_reg(tbo_pkg::REG_BOX_MAX_X, hx[tbo_pkg::CW-1:0]);
        write_reg(tbo_pkg::REG_BOX_MAX_Y, hy[tbo_pkg::CW-1:0]);
        write_reg(tbo_pkg::REG_BOX_MAX_Z, hz[tbo_pkg::CW-1:0]);
        write_reg(tbo_pkg::REG_TOLERANCE, tol[tbo_pkg::CW-1:0]);
    endtask

    function automatic tbo_pkg::tri_in_t mk_tri(input int ax, input int ay, input int az,
                                                input int bx, input int by, input int bz,
                                                input int cx, input int cy, input int cz);
        tbo_pkg::tri_in_t t;
        t.v0_x = tbo_pkg::coord_t'(ax); t.v0_y = tbo_pkg::coord_t'(ay);
        t.v0_z = tbo_pkg::coord_t'(az);
        t.v1_x = tbo_pkg::coord_t'(bx); t.v1_y = tbo_pkg::coord_t'(by);
        t.v1_z = tbo_pkg::coord_t'(bz);
        t.v2_x = tbo_pkg::coord_t'(cx); t.v2_y = tbo_pkg::coord_t'(cy);
        t.v2_z = tbo_pkg::coord_t'(cz);
        return t;
    endfunction

    function automatic tbo_pkg::coord_t near_coord(input int c, input int r);
        int off;
        off = int'($urandom_range(0, 2 * r)) - r;
        return tbo_pkg::coord_t'(c + off);
    endfunction

    // Mostly coordinates around the box, some fully random
    function automatic tbo_pkg::tri_in_t rand_tri();
        tbo_pkg::tri_in_t t;
        int               c [3];
        int               r [3];
        tbo_pkg::coord_t  p [9];
        for (int i = 0; i < 3; i++)
        begin
            c[i] = int'((box_lo[i] + box_hi[i]) / 2);
            r[i] = int'(box_hi[i] > box_lo[i] ? box_hi[i] - box_lo[i] : box_lo[i] - box_hi[i]);
            r[i] = r[i] + 64 + int'(tol_val > 4000000 ? 4000000 : tol_val);
            if (r[i] > 4000000) r[i] = 4000000;
        end
        for (int k = 0; k < 9; k++)
            p[k] = ($urandom_range(0, 9) == 0) ? tbo_pkg::coord_t'($urandom)
                                               : near_coord(c[k % 3], r[k % 3]);
        t = {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]};
        return t;
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_tri(rand_tri());
    endtask

    // Reset box is the single point at the origin
    task automatic test_reset_box();
        send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tri(mk_tri(-5, -5, -5, 5, 5, 5, 5, -5, 0));
        send_random(20);
    endtask

    task automatic test_directed();
        set_box(-1024, -1024, -1024, 1024, 1024, 1024, 0);
        send_tri(mk_tri(0, 0, 0, 100, 0, 0, 0, 100, 0));
        send_tri(mk_tri(2000, 0, 0, 3000, 10, 0, 2500, 500, 0));
        send_tri(mk_tri(0, -3000, 0, 10, -2000, 0, 5, -2500, 9));
        send_tri(mk_tri(0, 0, 2000, 10, 5, 3000, 5, 9, 2500));
        send_tri(mk_tri(-3000, 0, 0, -2000, 0, 0, -2500, 9, 9));
        // plane cutting the box corner: normal axis does not separate
        send_tri(mk_tri(3000, 0, 0, 0, 3000, 0, 0, 0, 3000));
        send_tri(mk_tri(1500, -1500, 0, 1500, 0, 1500, 0, -1500, 1500));
        // degenerate triangles (two points and a line), then one ordinary triangle
        send_tri(mk_tri(10, 10, 10, 10, 10, 10, 10, 10, 10));
        send_tri(mk_tri(2000, 2000, 0, 2000, 2000, 0, 2000, 2000, 0));
        send_tri(mk_tri(-900, 0, 1500, 1500, 0, -900, 300, 0, 300));
        send_tri(mk_tri(1100, 1100, -500, 1100, 1100, 500, 1500, 800, 0));
        // coordinate extremes
        send_tri(mk_tri(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                        8388607, 8388607, 8388607));
        send_tri(mk_tri(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                        -8388608, -8388608, -8388608));
        send_tri(mk_tri(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                        -8388608, -8388608, 8388607));
        send_tri(mk_tri(8388607, -8388608, 0, -8388608, 8388607, 0, 0, 0, 8388607));
        // tolerance just reaching the box on x, then just short of it on both sides
        set_box(-1024, -1024, -1024, 1024, 1024, 1024, 100);
        send_tri(mk_tri(1124, 0, 0, 1200, 10, 0, 1150, 20, 5));
        send_tri(mk_tri(1125, 0, 0, 1200, 10, 0, 1150, 20, 5));
        send_tri(mk_tri(-1125, 0, 0, -1200, 10, 0, -1150, 20, 5));
    endtask

    // Sweep box settings, extremes and unordered boxes among them
    task automatic test_random_sweep();
        set_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 32'hFFFFFF);
        send_random(120);
        set_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0);
        send_random(100);
        set_box(5000, -200, 300, -5000, 200, -300, 40);
        send_random(150);
        set_box(777, -777, 0, 777, -777, 0, 0);
        send_random(100);
        set_box(-300, -300, -300, 300, 300, 300, 0);
        quiet = 1'b1;
        send_random(200);
        quiet = 1'b0;
        for (int s = 0; s < 5; s++)
        begin
            set_box(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                    int'($urandom), int'($urandom), int'($urandom));
            send_random(60);
        end
        for (int s = 0; s < 3; s++)
        begin
            set_box(-int'($urandom_range(1, 60000)), -int'($urandom_range(1, 60000)),
                    -int'($urandom_range(1, 60000)), int'($urandom_range(0, 60000)),
                    int'($urandom_range(0, 60000)), int'($urandom_range(0, 60000)),
                    int'($urandom_range(0, 2000)));
            send_random(60);
        end
    endtask

    // A write to the unused index must leave the box alone
    task automatic test_unused_index();
        set_box(-2000, -2000, -2000, 2000, 2000, 2000, 10);
        write_reg(REG_UNUSED, (tbo_pkg::CW)'($urandom));
        send_random(40);
    endtask

    // Hold the receiver off while triangles keep coming, so the input stalls
    task automatic test_backpressure();
        drain();
        hold_req++;
        send_random(80);
    endtask

    // Receiver: random pop, with a long hold on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 17);
    end

    // Compare each popped verdict with the oldest prediction
    always @(posedge clk)
    begin
        tbo_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (verdict_q.size() == 0)
                report_mismatch("result with no triangle outstanding");
            else
            begin
                want = verdict_q.pop_front();
                if (result.intersects !== want.intersects)
                    report_mismatch($sformatf("intersects got %0b want %0b",
                                              result.intersects, want.intersects));
                if (result.separating_axis !== want.separating_axis)
                    report_mismatch($sformatf("separating_axis got %0d want %0d",
                                              result.separating_axis,
                                              want.separating_axis));
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= WATCH_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        item       = '0;
        wr_en      = 1'b0;
        wr_index   = '0;
        wr_data    = '0;
        mismatches = 0;
        stall_cnt  = 0;
        quiet      = 1'b0;
        hold_req   = 0;
        hold_seen  = 0;
        hold_left  = 0;
        tol_val    = 0;
        for (int i = 0; i < 3; i++)
        begin
            box_lo[i] = 0;
            box_hi[i] = 0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_box();
        test_directed();
        test_random_sweep();
        test_unused_index();
        test_backpressure();
        drain();

        if (verdict_q.size() != 0)
            report_mismatch("verdicts left outstanding");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
